// ===== sv/tcce_pkg.sv =====
// ============================================================================
// tcce_pkg: shared types and constants for the text console character engine
// Command codes, control characters, reset values and sequencer states.
// ============================================================================
package tcce_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Attribute after reset
    localparam logic [7:0] ATTR_RESET = 8'h07;

    // Command codes carried in tuser
    localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
    localparam logic [2:0] CMD_SET_CURSOR = 3'd1;
    localparam logic [2:0] CMD_SET_ATTR   = 3'd2;
    localparam logic [2:0] CMD_CLEAR      = 3'd3;
    localparam logic [2:0] CMD_PAINT      = 3'd4;
    localparam logic [2:0] CMD_READ_CELL  = 3'd5;

    // Control characters
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Columns a tab advances
    localparam int TAB_STEP = 4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_COPY,
        S_FILL,
        S_READ,
        S_DONE
    } t_state;

endpackage

// ===== sv/text_console_char_engine.sv =====
// ============================================================================
// text_console_char_engine: text-mode character console
// Cell store of COLUMNS x ROWS character/attribute pairs with a cursor and a
// current attribute, driven by one command per input transfer.
// ============================================================================
// One command is taken per input transfer and gives exactly one result transfer
// carrying the linear cursor position (and the cell contents for a read). The
// cell store is a single memory with one write and one read address a cycle,
// swept one cell per cycle by a small sequencer: put char without scroll, set
// cursor and set attribute go straight to the result, read cell passes through a
// read state, clear and paint fill every cell, and a put char that scrolls copies
// rows up one and then blanks the last used row.
// The block takes no command while one is in progress. After reset a clearing
// pass zeroes the store before the first command is taken. A finished result
// waits in an output register, so the next command is accepted while the result
// is still pending.
// ============================================================================
module text_console_char_engine #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: char_code[7:0], attribute[15:8], column[22:16], row[27:23],
    //        cell_index[38:28], zero pad[39]
    input  logic [39:0] i_s_tdata,
    // tuser: cmd[2:0]
    input  logic [2:0]  i_s_tuser,
    // Result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: cursor_position[10:0], cell_char[18:11], cell_attr[26:19],
    //        zero pad[31:27]
    output logic [31:0] o_m_tdata
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int COPY_END  = (ROWS - 2) * COLUMNS;
    localparam int SCROLL_END = (ROWS - 1) * COLUMNS - 1;

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [2:0]  in_cmd;
    logic [7:0]  in_char;
    logic [7:0]  in_attr;
    logic [6:0]  in_column;
    logic [4:0]  in_row;
    logic [10:0] in_index;

    assign in_cmd    = i_s_tuser;
    assign in_char   = i_s_tdata[7:0];
    assign in_attr   = i_s_tdata[15:8];
    assign in_column = i_s_tdata[22:16];
    assign in_row    = i_s_tdata[27:23];
    assign in_index  = i_s_tdata[38:28];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tcce_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [7:0]    r_attr, n_attr;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_end, n_end;
    logic [7:0]    r_fill_chr, n_fill_chr;
    logic [7:0]    r_fill_atr, n_fill_atr;
    logic          r_rd_ok, n_rd_ok;
    logic [7:0]    r_res_chr, n_res_chr;
    logic [7:0]    r_res_atr, n_res_atr;
    logic          r_m_tvalid, n_m_tvalid;
    logic [31:0]   r_m_tdata, n_m_tdata;
    logic [7:0]    r_rd_chr;
    logic [7:0]    r_rd_atr;

    // Cell store
    logic [7:0] mem_chr [CELLS];
    logic [7:0] mem_atr [CELLS];

    // Memory port controls
    logic          we_chr;
    logic          we_atr;
    logic [AW-1:0] wa;
    logic [7:0]    wd_chr;
    logic [7:0]    wd_atr;
    logic [AW-1:0] ra;

    logic accept;
    logic out_free;

    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    // ------------------------------------------------------------------
    // Cursor arithmetic for put char
    // ------------------------------------------------------------------
    logic [AW-1:0] cur_pos;
    logic [CW:0]   put_col;
    logic [RW:0]   put_row;
    logic          put_skip;
    logic          put_scroll;
    logic          put_print;

    assign cur_pos = AW'(AW'(r_row) * AW'(COLUMNS)) + AW'(r_col);

    always_comb begin
        put_col  = {1'b0, r_col};
        put_row  = {1'b0, r_row};
        put_skip = 1'b0;
        put_print = 1'b0;
        case (in_char)
            tcce_pkg::CH_BACKSPACE: begin
                if (cur_pos == '0) begin
                    put_skip = 1'b1;
                end else if (r_col == '0) begin
                    put_row = put_row - 1'b1;
                    put_col = (CW + 1)'(COLUMNS - 1);
                end else begin
                    put_col = put_col - 1'b1;
                end
            end
            tcce_pkg::CH_TAB: begin
                put_col = put_col + (CW + 1)'(tcce_pkg::TAB_STEP);
            end
            tcce_pkg::CH_NEWLINE, tcce_pkg::CH_NUL: begin
                put_row = put_row + 1'b1;
                put_col = '0;
            end
            default: begin
                put_print = 1'b1;
                put_col   = put_col + 1'b1;
            end
        endcase
        // wrap past the last column
        if (put_col >= (CW + 1)'(COLUMNS)) begin
            put_col = put_col - (CW + 1)'(COLUMNS);
            put_row = put_row + 1'b1;
        end
        // reaching the last row scrolls once
        put_scroll = !put_skip && (put_row >= (RW + 1)'(ROWS - 1));
        if (put_scroll) begin
            put_row = put_row - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcce_pkg::S_INIT: begin
                if (r_addr == AW'(CELLS - 1)) n_state = tcce_pkg::S_IDLE;
            end
            tcce_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        tcce_pkg::CMD_PUT_CHAR:
                            n_state = put_scroll ? tcce_pkg::S_COPY : tcce_pkg::S_DONE;
                        tcce_pkg::CMD_CLEAR, tcce_pkg::CMD_PAINT:
                            n_state = tcce_pkg::S_FILL;
                        tcce_pkg::CMD_READ_CELL:
                            n_state = tcce_pkg::S_READ;
                        default:
                            n_state = tcce_pkg::S_DONE;
                    endcase
                end
            end
            tcce_pkg::S_COPY: begin
                if (r_addr == AW'(COPY_END)) n_state = tcce_pkg::S_FILL;
            end
            tcce_pkg::S_FILL: begin
                if (r_addr == r_end) n_state = tcce_pkg::S_DONE;
            end
            tcce_pkg::S_READ: begin
                n_state = tcce_pkg::S_DONE;
            end
            tcce_pkg::S_DONE: begin
                if (out_free) n_state = tcce_pkg::S_IDLE;
            end
            default: begin
                n_state = tcce_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and memory port controls
    // ------------------------------------------------------------------
    always_comb begin
        o_s_tready = 1'b0;
        we_chr = 1'b0;
        we_atr = 1'b0;
        wa     = r_addr;
        wd_chr = r_fill_chr;
        wd_atr = r_fill_atr;
        ra     = AW'(in_index);
        case (r_state)
            tcce_pkg::S_INIT, tcce_pkg::S_FILL: begin
                we_chr = 1'b1;
                we_atr = 1'b1;
            end
            tcce_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid && in_cmd == tcce_pkg::CMD_PUT_CHAR) begin
                    if (in_char == tcce_pkg::CH_BACKSPACE) begin
                        // blank the previous cell, keep its attribute
                        we_chr = !put_skip;
                        wa     = cur_pos - 1'b1;
                        wd_chr = '0;
                    end else if (put_print) begin
                        we_chr = 1'b1;
                        we_atr = 1'b1;
                        wa     = cur_pos;
                        wd_chr = in_char;
                        wd_atr = r_attr;
                    end
                end
            end
            tcce_pkg::S_COPY: begin
                // read one row ahead, write the cell read last cycle
                ra     = r_addr + AW'(COLUMNS);
                we_chr = (r_addr != '0);
                we_atr = (r_addr != '0);
                wa     = r_addr - 1'b1;
                wd_chr = r_rd_chr;
                wd_atr = r_rd_atr;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_attr     = r_attr;
        n_addr     = r_addr;
        n_end      = r_end;
        n_fill_chr = r_fill_chr;
        n_fill_atr = r_fill_atr;
        n_rd_ok    = r_rd_ok;
        n_res_chr  = r_res_chr;
        n_res_atr  = r_res_atr;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        case (r_state)
            tcce_pkg::S_INIT, tcce_pkg::S_FILL: begin
                n_addr = r_addr + 1'b1;
            end
            tcce_pkg::S_IDLE: begin
                if (accept) begin
                    n_res_chr = '0;
                    n_res_atr = '0;
                    n_addr    = '0;
                    case (in_cmd)
                        tcce_pkg::CMD_PUT_CHAR: begin
                            n_col      = put_col[CW-1:0];
                            n_row      = put_row[RW-1:0];
                            n_end      = AW'(SCROLL_END);
                            n_fill_chr = '0;
                            n_fill_atr = r_attr;
                        end
                        tcce_pkg::CMD_SET_CURSOR: begin
                            n_col = ({25'd0, in_column} >= 32'(COLUMNS)) ?
                                    CW'(COLUMNS - 1) : CW'(in_column);
                            n_row = ({27'd0, in_row} >= 32'(ROWS)) ?
                                    RW'(ROWS - 1) : RW'(in_row);
                        end
                        tcce_pkg::CMD_SET_ATTR: begin
                            n_attr = in_attr;
                        end
                        tcce_pkg::CMD_CLEAR: begin
                            n_col      = '0;
                            n_row      = '0;
                            n_end      = AW'(CELLS - 1);
                            n_fill_chr = '0;
                            n_fill_atr = r_attr;
                        end
                        tcce_pkg::CMD_PAINT: begin
                            n_attr     = in_attr;
                            n_end      = AW'(CELLS - 1);
                            n_fill_chr = tcce_pkg::CH_SPACE;
                            n_fill_atr = in_attr;
                        end
                        tcce_pkg::CMD_READ_CELL: begin
                            n_rd_ok = ({21'd0, in_index} < 32'(CELLS));
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tcce_pkg::S_COPY: begin
                // hold at the end so the fill starts at the first blank row
                if (r_addr != AW'(COPY_END)) n_addr = r_addr + 1'b1;
            end
            tcce_pkg::S_READ: begin
                n_res_chr = r_rd_ok ? r_rd_chr : '0;
                n_res_atr = r_rd_ok ? r_rd_atr : '0;
            end
            tcce_pkg::S_DONE: begin
                if (out_free) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {5'd0, r_res_atr, r_res_chr, 11'(cur_pos)};
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tcce_pkg::S_INIT;
            r_col      <= '0;
            r_row      <= '0;
            r_attr     <= tcce_pkg::ATTR_RESET;
            r_addr     <= '0;
            r_end      <= AW'(CELLS - 1);
            r_fill_chr <= '0;
            r_fill_atr <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_attr     <= n_attr;
            r_addr     <= n_addr;
            r_end      <= n_end;
            r_fill_chr <= n_fill_chr;
            r_fill_atr <= n_fill_atr;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_ok   <= n_rd_ok;
        r_res_chr <= n_res_chr;
        r_res_atr <= n_res_atr;
        r_m_tdata <= n_m_tdata;
    end

    // ------------------------------------------------------------------
    // Cell store: one write, one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (we_chr) mem_chr[wa] <= wd_chr;
        if (we_atr) mem_atr[wa] <= wd_atr;
        r_rd_chr <= mem_chr[ra];
        r_rd_atr <= mem_atr[ra];
    end

endmodule
